@@ design/arq_pkg.sv @@
// ----------------------------------------------------------------------------
// arq_pkg
// Types, codes and reset values shared by the stop-and-wait transmit
// controller.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    localparam logic [1:0] OP_PAYLOAD = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    localparam logic [7:0] FT_DATA = 8'd1;
    localparam logic [7:0] FT_ACK  = 8'd2;

    localparam logic [1:0] FK_DATA = 2'd1;
    localparam logic [1:0] FK_ACK  = 2'd2;

    localparam logic [1:0] RK_NEW     = 2'd0;
    localparam logic [1:0] RK_RETX    = 2'd1;
    localparam logic [1:0] RK_ACK     = 2'd2;
    localparam logic [1:0] RK_SUCCESS = 2'd3;

    localparam logic [2:0] CMD_PAYLOAD   = 3'd0;
    localparam logic [2:0] CMD_OWN_DATA  = 3'd1;
    localparam logic [2:0] CMD_ACK       = 3'd2;
    localparam logic [2:0] CMD_PEER_DATA = 3'd3;
    localparam logic [2:0] CMD_IDLE      = 3'd4;

    localparam logic [2:0] REG_MY_ADDR   = 3'd0;
    localparam logic [2:0] REG_PEER_ADDR = 3'd1;
    localparam logic [2:0] REG_MAX_RETX  = 3'd2;
    localparam logic [2:0] REG_BUF_LIMIT = 3'd3;
    localparam logic [2:0] REG_INC_EN    = 3'd4;
    localparam logic [2:0] REG_START_IDX = 3'd5;

    localparam logic [7:0] MAX_RETX_RST  = 8'd3;
    localparam logic [4:0] BUF_LIMIT_RST = 5'd16;
    localparam logic       INC_EN_RST    = 1'b1;
    localparam logic [7:0] START_IDX_RST = 8'd0;

    typedef struct packed {
        logic [7:0] my_address;
        logic [7:0] peer_address;
        logic [7:0] max_retx;
        logic [4:0] buffer_limit;
        logic       inc_en;
        logic [7:0] start_index;
        logic       load_start;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [7:0]  length;
        logic [7:0]  src;
        logic [7:0]  idx;
        logic [7:0]  txc;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  frame_kind;
        logic [7:0]  frame_number;
        logic [7:0]  dest_out;
        logic [7:0]  source_out;
        logic [7:0]  tx_count_out;
        logic [15:0] handle_out;
        logic [7:0]  length_out;
        logic        last;
    } res_t;

endpackage

@@ design/arq_regs.sv @@
// ----------------------------------------------------------------------------
// arq_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module arq_regs
    import arq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [7:0] my_reg;
    logic [7:0] peer_reg;
    logic [7:0] retx_reg;
    logic [4:0] limit_reg;
    logic       inc_reg;
    logic [7:0] start_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_reg    <= '0;
            peer_reg  <= '0;
            retx_reg  <= MAX_RETX_RST;
            limit_reg <= BUF_LIMIT_RST;
            inc_reg   <= INC_EN_RST;
            start_reg <= START_IDX_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MY_ADDR:   my_reg    <= pwdata[7:0];
                REG_PEER_ADDR: peer_reg  <= pwdata[7:0];
                REG_MAX_RETX:  retx_reg  <= pwdata[7:0];
                REG_BUF_LIMIT: limit_reg <= pwdata[4:0];
                REG_INC_EN:    inc_reg   <= pwdata[0];
                REG_START_IDX: start_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MY_ADDR:   prdata = PDATA_W'(my_reg);
            REG_PEER_ADDR: prdata = PDATA_W'(peer_reg);
            REG_MAX_RETX:  prdata = PDATA_W'(retx_reg);
            REG_BUF_LIMIT: prdata = PDATA_W'(limit_reg);
            REG_INC_EN:    prdata = PDATA_W'(inc_reg);
            REG_START_IDX: prdata = PDATA_W'(start_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.my_address   = my_reg;
        cfg.peer_address = peer_reg;
        cfg.max_retx     = retx_reg;
        cfg.buffer_limit = limit_reg;
        cfg.inc_en       = inc_reg;
        cfg.start_index  = pwdata[7:0];
        cfg.load_start   = wr_en && (reg_sel == REG_START_IDX);
    end

endmodule

@@ design/arq_front.sv @@
// ----------------------------------------------------------------------------
// arq_front
// Accepts input items, classifies each into a command and holds commands in
// a two-entry queue. Items that cause nothing are dropped here.
// ----------------------------------------------------------------------------
module arq_front
    import arq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [15:0] payload_handle,
    input  logic [7:0]  payload_bytes,
    input  logic [7:0]  report_type,
    input  logic [7:0]  report_source,
    input  logic [7:0]  report_destination,
    input  logic [7:0]  report_index,
    input  logic [7:0]  report_tx_count,
    input  logic        reset_flag,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       new_cmd;
    logic       keep;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        new_cmd.kind   = CMD_PAYLOAD;
        new_cmd.handle = payload_handle;
        new_cmd.length = payload_bytes;
        new_cmd.src    = report_source;
        new_cmd.idx    = report_index;
        new_cmd.txc    = report_tx_count;
        keep           = 1'b0;
        priority if (operation == OP_PAYLOAD)
        begin
            keep = 1'b1;
        end
        else if (operation == OP_REPORT)
        begin
            priority if (report_source == cfg.my_address)
            begin
                new_cmd.kind = CMD_OWN_DATA;
                keep         = (report_type == FT_DATA);
            end
            else if (report_destination == cfg.my_address)
            begin
                if (report_type == FT_ACK)
                begin
                    new_cmd.kind = CMD_ACK;
                    keep         = 1'b1;
                end
                else if (report_type == FT_DATA)
                begin
                    new_cmd.kind = CMD_PEER_DATA;
                    keep         = 1'b1;
                end
            end
            else
            begin
                keep = 1'b0;
            end
        end
        else if (operation == OP_RESET)
        begin
            new_cmd.kind = CMD_IDLE;
            keep         = reset_flag;
        end
        else
        begin
            keep = 1'b0;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full && keep;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ design/arq_back.sv @@
// ----------------------------------------------------------------------------
// arq_back
// Carries out commands: owns the descriptor queue, the idle flag, the frame
// index counter and the frame in flight, and produces result items.
// ----------------------------------------------------------------------------
module arq_back
    import arq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic outq_full,
    output logic res_push,
    output res_t res
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

    localparam logic PH_FIRST = 1'b0;
    localparam logic PH_POP   = 1'b1;

    logic [31:0]       mem [QUEUE_DEPTH];
    logic [31:0]       rd_data_reg;
    logic              phase_reg,    phase_next;
    logic              idle_reg,     idle_next;
    logic [7:0]        index_reg,    index_next;
    logic [PTR_W-1:0]  head_reg,     head_next;
    logic [PTR_W-1:0]  tail_reg,     tail_next;
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic [31:0]       inflight_reg, inflight_next;
    logic              mem_we;
    logic [7:0]        new_index;
    logic [31:0]       entry;
    logic              room;
    logic              queued;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic res_t data_res(input logic [1:0] kind, input logic [31:0] frame,
                                      input logic [7:0] txc, input cfg_t c,
                                      input logic lst);
        res_t r;
        r.result_kind  = kind;
        r.frame_kind   = FK_DATA;
        r.frame_number = frame[7:0];
        r.dest_out     = c.peer_address;
        r.source_out   = c.my_address;
        r.tx_count_out = txc;
        r.handle_out   = frame[31:16];
        r.length_out   = frame[15:8];
        r.last         = lst;
        return r;
    endfunction

    assign new_index = cfg.inc_en ? index_reg + 8'd1 : index_reg;
    assign entry     = {cmd.handle, cmd.length, new_index};
    assign queued    = (fill_reg != '0);
    assign room      = (CMP_W'(fill_reg) < CMP_W'(cfg.buffer_limit))
                       && (fill_reg < FILL_W'(QUEUE_DEPTH));

    always_comb
    begin
        phase_next    = phase_reg;
        idle_next     = idle_reg;
        index_next    = index_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        inflight_next = inflight_reg;
        mem_we        = 1'b0;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        res           = '0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (cmd_valid && !outq_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_PAYLOAD:
                        begin
                            if (room)
                            begin
                                index_next = new_index;
                                tail_next  = ptr_inc(tail_reg);
                                if (idle_reg)
                                begin
                                    head_next     = ptr_inc(head_reg);
                                    inflight_next = entry;
                                    idle_next     = 1'b0;
                                    res_push      = 1'b1;
                                    res           = data_res(RK_NEW, entry, 8'd0, cfg, 1'b1);
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        CMD_OWN_DATA:
                        begin
                            if (cmd.txc >= cfg.max_retx)
                            begin
                                idle_next  = !queued;
                                phase_next = queued ? PH_POP : PH_FIRST;
                            end
                            else
                            begin
                                res_push = 1'b1;
                                res      = data_res(RK_RETX, inflight_reg, cmd.txc + 8'd1,
                                                    cfg, 1'b1);
                            end
                        end
                        CMD_ACK:
                        begin
                            idle_next       = !queued;
                            phase_next      = queued ? PH_POP : PH_FIRST;
                            res_push        = 1'b1;
                            res.result_kind = RK_SUCCESS;
                            res.last        = !queued;
                        end
                        CMD_PEER_DATA:
                        begin
                            idle_next        = 1'b0;
                            res_push         = 1'b1;
                            res.result_kind  = RK_ACK;
                            res.frame_kind   = FK_ACK;
                            res.frame_number = cmd.idx;
                            res.dest_out     = cmd.src;
                            res.source_out   = cfg.my_address;
                            res.last         = 1'b1;
                        end
                        CMD_IDLE:
                        begin
                            idle_next  = !queued;
                            phase_next = queued ? PH_POP : PH_FIRST;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_POP:
            begin
                if (!outq_full)
                begin
                    inflight_next = rd_data_reg;
                    head_next     = ptr_inc(head_reg);
                    fill_next     = fill_reg - 1'b1;
                    phase_next    = PH_FIRST;
                    res_push      = 1'b1;
                    res           = data_res(RK_NEW, rd_data_reg, 8'd0, cfg, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
        if (cfg.load_start)
        begin
            index_next = cfg.start_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= entry;
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            idle_reg     <= 1'b1;
            index_reg    <= START_IDX_RST;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idle_reg     <= idle_next;
            index_reg    <= index_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            inflight_reg <= inflight_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg |-> fill_reg == '0)
        else $error("Controller is idle while descriptors are queued.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("Descriptor queue fill exceeds its depth.");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POP |-> fill_reg != '0)
        else $error("Release cycle entered with an empty descriptor queue.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !outq_full)
        else $error("Result item written into a full result queue.");

    a_pop_releases: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POP && !outq_full |=> phase_reg == PH_FIRST && !idle_reg)
        else $error("Released descriptor did not leave the controller busy.");
`endif

endmodule

@@ design/arq_outq.sv @@
// ----------------------------------------------------------------------------
// arq_outq
// Two-entry result queue; decouples the result port from the command
// engine.
// ----------------------------------------------------------------------------
module arq_outq
    import arq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t din,
    output logic is_full,
    input  logic rd_en,
    output logic is_empty,
    output res_t dout
);

    res_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign is_full  = (count_reg == 2'd2);
    assign is_empty = (count_reg == 2'd0);
    assign dout     = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ design/stop_and_wait_arq_controller_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_controller_core
// Stop-and-wait transmit controller: queues payload descriptors, sends and
// retransmits data frames, answers data frames with acks and reports success.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle into a two-entry command queue
// while full is low, so full rises only when the command engine falls
// behind. The engine executes a command in its first phase, followed by a
// release phase when it releases a queued descriptor, which reads the
// descriptor memory through its registered read port; it takes no new
// command in that phase and stalls while the result queue is full. Each item
// gives zero, one or two result items, held in a two-entry result queue
// whose last field marks the final result of an item. No clearing after reset.
module stop_and_wait_arq_controller_core
    import arq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         operation,
    input  logic [15:0]        payload_handle,
    input  logic [7:0]         payload_bytes,
    input  logic [7:0]         report_type,
    input  logic [7:0]         report_source,
    input  logic [7:0]         report_destination,
    input  logic [7:0]         report_index,
    input  logic [7:0]         report_tx_count,
    input  logic               reset_flag,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         result_kind,
    output logic [1:0]         frame_kind,
    output logic [7:0]         frame_number,
    output logic [7:0]         dest_out,
    output logic [7:0]         source_out,
    output logic [7:0]         tx_count_out,
    output logic [15:0]        handle_out,
    output logic [7:0]         length_out,
    output logic               last
);

    cfg_t cfg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic outq_full;
    logic res_push;
    res_t res;
    res_t res_out;

    arq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arq_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .push               (push),
        .full               (full),
        .operation          (operation),
        .payload_handle     (payload_handle),
        .payload_bytes      (payload_bytes),
        .report_type        (report_type),
        .report_source      (report_source),
        .report_destination (report_destination),
        .report_index       (report_index),
        .report_tx_count    (report_tx_count),
        .reset_flag         (reset_flag),
        .cmd_valid          (cmd_valid),
        .cmd                (cmd),
        .cmd_pop            (cmd_pop)
    );

    arq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .outq_full (outq_full),
        .res_push  (res_push),
        .res       (res)
    );

    arq_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .din      (res),
        .is_full  (outq_full),
        .rd_en    (pop),
        .is_empty (empty),
        .dout     (res_out)
    );

    assign result_kind  = res_out.result_kind;
    assign frame_kind   = res_out.frame_kind;
    assign frame_number = res_out.frame_number;
    assign dest_out     = res_out.dest_out;
    assign source_out   = res_out.source_out;
    assign tx_count_out = res_out.tx_count_out;
    assign handle_out   = res_out.handle_out;
    assign length_out   = res_out.length_out;
    assign last         = res_out.last;

endmodule

@@ dv/arq_checker.sv @@
// ----------------------------------------------------------------------------
// arq_checker
// Watches the register port and both item channels of the stop-and-wait
// transmit controller. It keeps its own copy of the registers and the link
// state, predicts the results of every accepted item and compares each
// popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module arq_checker
    import arq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         operation,
    input  logic [15:0]        payload_handle,
    input  logic [7:0]         payload_bytes,
    input  logic [7:0]         report_type,
    input  logic [7:0]         report_source,
    input  logic [7:0]         report_destination,
    input  logic [7:0]         report_index,
    input  logic [7:0]         report_tx_count,
    input  logic               reset_flag,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         result_kind,
    input  logic [1:0]         frame_kind,
    input  logic [7:0]         frame_number,
    input  logic [7:0]         dest_out,
    input  logic [7:0]         source_out,
    input  logic [7:0]         tx_count_out,
    input  logic [15:0]        handle_out,
    input  logic [7:0]         length_out,
    input  logic               last,
    output int                 fail_count,
    output int                 outstanding,
    output int                 checked
);

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  length;
        logic [7:0]  index;
    } desc_t;

    logic [7:0] my_addr;
    logic [7:0] peer_addr;
    logic [7:0] retx_limit;
    logic [4:0] buf_limit;
    logic       inc_en;

    logic       link_idle;
    logic [7:0] next_index;
    desc_t      backlog[$];
    desc_t      in_flight;
    desc_t      fresh;

    res_t       expected_results[$];
    res_t       batch[0:1];
    int         batch_n;
    int         room;
    res_t       note;
    res_t       want;

    function automatic res_t sent_data(input logic [1:0] kind, input desc_t d,
                                       input logic [7:0] txc);
        res_t r;
        r.result_kind  = kind;
        r.frame_kind   = FK_DATA;
        r.frame_number = d.index;
        r.dest_out     = peer_addr;
        r.source_out   = my_addr;
        r.tx_count_out = txc;
        r.handle_out   = d.handle;
        r.length_out   = d.length;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic add_result(input res_t r);
        batch[batch_n] = r;
        batch_n++;
    endtask

    task automatic send_oldest();
        if (backlog.size() != 0)
        begin
            in_flight = backlog.pop_front();
            link_idle = 1'b0;
            add_result(sent_data(RK_NEW, in_flight, 8'd0));
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_addr     = 8'd0;
            peer_addr   = 8'd0;
            retx_limit  = MAX_RETX_RST;
            buf_limit   = BUF_LIMIT_RST;
            inc_en      = INC_EN_RST;
            link_idle   = 1'b1;
            next_index  = START_IDX_RST;
            in_flight   = '0;
            backlog.delete();
            expected_results.delete();
            fail_count  = 0;
            checked     = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_MY_ADDR:   my_addr = pwdata[7:0];
                    REG_PEER_ADDR: peer_addr = pwdata[7:0];
                    REG_MAX_RETX:  retx_limit = pwdata[7:0];
                    REG_BUF_LIMIT: buf_limit = pwdata[4:0];
                    REG_INC_EN:    inc_en = pwdata[0];
                    REG_START_IDX: next_index = pwdata[7:0];
                    default: ;
                endcase
            end

            if (push && !full)
            begin
                batch_n = 0;
                case (operation)
                    OP_PAYLOAD:
                    begin
                        room = (int'(buf_limit) < QUEUE_DEPTH_DEF) ? int'(buf_limit)
                                                                   : QUEUE_DEPTH_DEF;
                        if (backlog.size() < room)
                        begin
                            if (inc_en)
                                next_index = next_index + 8'd1;
                            fresh.handle = payload_handle;
                            fresh.length = payload_bytes;
                            fresh.index  = next_index;
                            backlog.push_back(fresh);
                            if (link_idle)
                                send_oldest();
                        end
                    end
                    OP_REPORT:
                    begin
                        if (report_source == my_addr)
                        begin
                            if (report_type == FT_DATA)
                            begin
                                if (report_tx_count >= retx_limit)
                                begin
                                    link_idle = 1'b1;
                                    send_oldest();
                                end
                                else
                                    add_result(sent_data(RK_RETX, in_flight,
                                                         report_tx_count + 8'd1));
                            end
                        end
                        else if (report_destination == my_addr)
                        begin
                            if (report_type == FT_ACK)
                            begin
                                link_idle = 1'b1;
                                note = '0;
                                note.result_kind = RK_SUCCESS;
                                add_result(note);
                                send_oldest();
                            end
                            else if (report_type == FT_DATA)
                            begin
                                link_idle = 1'b0;
                                note = '0;
                                note.result_kind  = RK_ACK;
                                note.frame_kind   = FK_ACK;
                                note.frame_number = report_index;
                                note.dest_out     = report_source;
                                note.source_out   = my_addr;
                                add_result(note);
                            end
                        end
                    end
                    OP_RESET:
                    begin
                        if (reset_flag)
                        begin
                            link_idle = 1'b1;
                            send_oldest();
                        end
                    end
                    default: ;
                endcase
                if (batch_n > 0)
                    batch[batch_n-1].last = 1'b1;
                for (int i = 0; i < batch_n; i++)
                    expected_results.push_back(batch[i]);
            end

            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result item of kind %0d arrived with nothing expected",
                           result_kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    check_field("result_kind", 32'(want.result_kind), 32'(result_kind));
                    check_field("frame_kind", 32'(want.frame_kind), 32'(frame_kind));
                    check_field("frame_number", 32'(want.frame_number),
                                32'(frame_number));
                    check_field("dest_out", 32'(want.dest_out), 32'(dest_out));
                    check_field("source_out", 32'(want.source_out), 32'(source_out));
                    check_field("tx_count_out", 32'(want.tx_count_out),
                                32'(tx_count_out));
                    check_field("handle_out", 32'(want.handle_out), 32'(handle_out));
                    check_field("length_out", 32'(want.length_out), 32'(length_out));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the stop-and-wait transmit controller through a directed set of
// events and then several phases of random link traffic under different
// register settings, with random idling on both sides and one long result
// stall. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import arq_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 20;
    localparam int         HOLD_AT     = 400;
    localparam int         HOLD_LEN    = 400;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] handle;
        logic [7:0]  bytes;
        logic [7:0]  rtype;
        logic [7:0]  rsrc;
        logic [7:0]  rdst;
        logic [7:0]  ridx;
        logic [7:0]  rtxc;
        logic        rflag;
    } link_event_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               push;
    logic               full;
    logic [1:0]         operation;
    logic [15:0]        payload_handle;
    logic [7:0]         payload_bytes;
    logic [7:0]         report_type;
    logic [7:0]         report_source;
    logic [7:0]         report_destination;
    logic [7:0]         report_index;
    logic [7:0]         report_tx_count;
    logic               reset_flag;
    logic               empty;
    logic               pop;
    logic [1:0]         result_kind;
    logic [1:0]         frame_kind;
    logic [7:0]         frame_number;
    logic [7:0]         dest_out;
    logic [7:0]         source_out;
    logic [7:0]         tx_count_out;
    logic [15:0]        handle_out;
    logic [7:0]         length_out;
    logic               last;

    int fail_count;
    int outstanding;
    int checked;
    int items_sent;
    int settings_used;

    logic [7:0] cur_my;
    logic [7:0] cur_max;

    wire calm = (items_sent >= 700) && (items_sent < 900);

    stop_and_wait_arq_controller_core dut (.*);

    arq_checker arq_watch (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= calm || ($urandom_range(99) >= 26);
        end
    end

    function automatic link_event_t noise();
        link_event_t e;
        e.op     = 2'($urandom_range(3));
        e.handle = 16'($urandom);
        e.bytes  = 8'($urandom);
        e.rtype  = 8'($urandom);
        e.rsrc   = 8'($urandom);
        e.rdst   = 8'($urandom);
        e.ridx   = 8'($urandom);
        e.rtxc   = 8'($urandom);
        e.rflag  = 1'($urandom);
        return e;
    endfunction

    function automatic link_event_t payload(input logic [15:0] h, input logic [7:0] len);
        link_event_t e;
        e = noise();
        e.op     = OP_PAYLOAD;
        e.handle = h;
        e.bytes  = len;
        return e;
    endfunction

    function automatic link_event_t report(input logic [7:0] typ, input logic [7:0] src,
                                           input logic [7:0] dst, input logic [7:0] txc);
        link_event_t e;
        e = noise();
        e.op    = OP_REPORT;
        e.rtype = typ;
        e.rsrc  = src;
        e.rdst  = dst;
        e.rtxc  = txc;
        return e;
    endfunction

    function automatic link_event_t idle_event(input logic flag);
        link_event_t e;
        e = noise();
        e.op    = OP_RESET;
        e.rflag = flag;
        return e;
    endfunction

    function automatic link_event_t random_event();
        int         pick;
        int         hi;
        logic [7:0] other;
        logic [7:0] txc;
        logic [7:0] odd_type;
        pick  = $urandom_range(99);
        other = cur_my ^ 8'($urandom_range(1, 255));
        hi    = (cur_max < 8'd255) ? cur_max + 1 : 255;
        txc   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(hi));
        odd_type = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
        if (pick < 32)
            return payload(16'($urandom), 8'($urandom));
        else if (pick < 48)
            return report(FT_DATA, cur_my, 8'($urandom), txc);
        else if (pick < 66)
            return report(FT_ACK, other, cur_my, 8'($urandom));
        else if (pick < 74)
            return report(FT_DATA, other, cur_my, 8'($urandom));
        else if (pick < 82)
            return idle_event($urandom_range(3) != 0);
        else if (pick < 86)
            return report(FT_ACK, cur_my, 8'($urandom), 8'($urandom));
        else if (pick < 90)
            return report(odd_type, other, cur_my, 8'($urandom));
        else if (pick < 94)
            return report(8'($urandom_range(1, 2)), other,
                          cur_my ^ 8'($urandom_range(1, 255)), 8'($urandom));
        return noise();
    endfunction

    task automatic offer(input link_event_t e);
        while (!calm && $urandom_range(99) < 26)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push               <= 1'b1;
        operation          <= e.op;
        payload_handle     <= e.handle;
        payload_bytes      <= e.bytes;
        report_type        <= e.rtype;
        report_source      <= e.rsrc;
        report_destination <= e.rdst;
        report_index       <= e.ridx;
        report_tx_count    <= e.rtxc;
        reset_flag         <= e.rflag;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] my, input logic [7:0] peer,
                             input logic [7:0] retx, input logic [4:0] limit,
                             input logic inc, input logic [7:0] start);
        reg_write(REG_MY_ADDR, {24'd0, my});
        reg_write(REG_PEER_ADDR, {24'd0, peer});
        reg_write(REG_MAX_RETX, {24'd0, retx});
        reg_write(REG_BUF_LIMIT, {27'd0, limit});
        reg_write(REG_INC_EN, {31'd0, inc});
        reg_write(REG_START_IDX, {24'd0, start});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_my  = my;
        cur_max = retx;
        settings_used++;
    endtask

    task automatic random_traffic(input int count);
        for (int i = 0; i < count; i++)
            offer(random_event());
        drain();
    endtask

    initial
    begin
        link_event_t e;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        push               = 1'b0;
        operation          = OP_PAYLOAD;
        payload_handle     = '0;
        payload_bytes      = '0;
        report_type        = '0;
        report_source      = '0;
        report_destination = '0;
        report_index       = '0;
        report_tx_count    = '0;
        reset_flag         = 1'b0;
        items_sent         = 0;
        settings_used      = 0;
        cur_my             = '0;
        cur_max            = MAX_RETX_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first report retransmits a frame that was never sent.
        configure(8'h5A, 8'hA5, 8'd2, 5'd2, 1'b1, 8'hFE);
        offer(report(FT_DATA, 8'h5A, 8'h00, 8'h00));
        offer(payload(16'hFFFF, 8'hFF));
        offer(payload(16'h0000, 8'h00));
        offer(payload(16'h1234, 8'h56));
        offer(payload(16'hABCD, 8'hEF));
        offer(report(FT_DATA, 8'h5A, 8'hFF, 8'h01));
        offer(report(FT_DATA, 8'h5A, 8'h00, 8'h02));
        offer(report(FT_ACK, 8'hA5, 8'h5A, 8'h00));
        offer(report(FT_ACK, 8'hA5, 8'h5A, 8'hFF));
        offer(report(FT_DATA, 8'hA5, 8'h5A, 8'h00));
        offer(report(FT_ACK, 8'h5A, 8'hA5, 8'h00));
        offer(report(8'hFF, 8'hA5, 8'h5A, 8'h00));
        offer(report(8'h00, 8'hA5, 8'h5A, 8'h00));
        offer(report(FT_DATA, 8'h33, 8'h44, 8'h00));
        offer(idle_event(1'b0));
        offer(idle_event(1'b1));
        e = noise();
        e.op = OP_UNUSED;
        offer(e);
        offer(report(FT_DATA, 8'h5A, 8'h00, 8'hFF));
        offer(payload(16'h8001, 8'h80));
        offer(report(FT_DATA, 8'h5A, 8'h00, 8'h00));
        drain();

        configure(8'h00, 8'hFF, 8'd0, 5'd16, 1'b0, 8'h00);
        random_traffic(280);
        configure(8'hFF, 8'h00, 8'd255, 5'd1, 1'b1, 8'h80);
        random_traffic(280);
        configure(8'($urandom), 8'($urandom), 8'($urandom_range(1, 5)),
                  5'($urandom_range(2, 8)), 1'b1, 8'($urandom));
        random_traffic(280);
        configure(8'($urandom), 8'($urandom), 8'($urandom_range(0, 255)), 5'd0,
                  1'($urandom), 8'($urandom));
        random_traffic(130);
        configure(8'($urandom), 8'($urandom), 8'd3, 5'($urandom_range(1, 16)),
                  1'($urandom), 8'hFF);
        random_traffic(360);

        $display("Run covered %0d link events over %0d register settings; %0d results compared.",
                 items_sent, settings_used, checked);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
